@@ sv/reb_pkg.sv @@
// Shared types and codes for the rotary encoder button event block.
// No dependencies; every other file in sv/ imports this package.
package reb_pkg;

    localparam int CountWidth = 8;
    localparam int TimeWidth  = 32;
    localparam int HoldWidth  = 16;

    localparam logic [HoldWidth-1:0] LongPressReset = 16'd1000;
    localparam logic signed [CountWidth-1:0] CountMax = 8'sd127;
    localparam logic signed [CountWidth-1:0] CountMin = -8'sd127;

    typedef enum logic [1:0] {
        FUNC_PIN  = 2'd0,
        FUNC_TICK = 2'd1,
        FUNC_POLL = 2'd2,
        FUNC_IDLE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_CLICK = 3'd3,
        EV_LONG  = 3'd4
    } event_t;

    typedef struct packed {
        logic [1:0] func;
        logic       clk_level;
        logic       dt_level;
        logic       switch_level;
    } reb_item_t;

    typedef struct packed {
        logic       has_result;
        logic [2:0] event_code;
    } reb_result_t;

endpackage

@@ sv/reb_in_stage.sv @@
// Input register for the rotary encoder button event block.
// Depends on reb_pkg for the item type.
module reb_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  reb_pkg::reb_item_t in_item,
    input  logic               advance,
    output logic               in_stall,
    output logic               item_valid,
    output reb_pkg::reb_item_t item
);
    import reb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    reb_item_t item_reg;
    logic      accept;

    // Stall only while a held beat cannot move on this cycle.
    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ sv/reb_core.sv @@
// Encoder count, millisecond timer and press timer state with event decode.
// Depends on reb_pkg for item, result and code types.
module reb_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [reb_pkg::HoldWidth-1:0]  cfg_wr_data,
    input  reb_pkg::reb_item_t             item,
    input  logic                           advance,
    output reb_pkg::reb_result_t           result
);
    import reb_pkg::*;

    logic signed [CountWidth-1:0] count_reg, count_next;
    logic                         last_clock_reg, last_clock_next;
    logic                         down_reg, down_next;
    logic                         long_done_reg, long_done_next;
    logic [TimeWidth-1:0]         start_reg, start_next;
    logic [TimeWidth-1:0]         ms_reg, ms_next;
    logic [HoldWidth-1:0]         long_press_reg;

    logic                 pressed;
    logic                 new_press;
    logic                 long_done_eff;
    logic [TimeWidth-1:0] held;
    logic                 held_short;
    logic [2:0]           ev;

    assign pressed       = !item.switch_level;
    assign new_press     = pressed && !down_reg;
    assign long_done_eff = new_press ? 1'b0 : long_done_reg;
    assign held          = new_press ? '0 : (ms_reg - start_reg);
    assign held_short    = held < {{(TimeWidth-HoldWidth){1'b0}}, long_press_reg};

    always_comb
    begin
        count_next      = count_reg;
        last_clock_next = last_clock_reg;
        down_next       = down_reg;
        long_done_next  = long_done_reg;
        start_next      = start_reg;
        ms_next         = ms_reg;
        ev              = EV_NONE;
        case (func_t'(item.func))
            FUNC_PIN:
            begin
                if (item.clk_level != last_clock_reg)
                begin
                    last_clock_next = item.clk_level;
                    // Count only on the falling clock edge; saturate at the limits.
                    if (!item.clk_level)
                    begin
                        if (item.dt_level != item.clk_level)
                        begin
                            if (count_reg < CountMax)
                            begin
                                count_next = count_reg + 8'sd1;
                            end
                        end
                        else if (count_reg > CountMin)
                        begin
                            count_next = count_reg - 8'sd1;
                        end
                    end
                end
            end
            FUNC_TICK:
            begin
                ms_next = ms_reg + 32'd1;
            end
            FUNC_POLL:
            begin
                count_next = '0;
                if (count_reg > 0)
                begin
                    ev = EV_CW;
                end
                else if (count_reg < 0)
                begin
                    ev = EV_CCW;
                end
                else
                begin
                    if (new_press)
                    begin
                        down_next      = 1'b1;
                        long_done_next = 1'b0;
                        start_next     = ms_reg;
                    end
                    if (down_reg || pressed)
                    begin
                        if (!pressed)
                        begin
                            down_next = 1'b0;
                            if (!long_done_eff && held_short)
                            begin
                                ev = EV_CLICK;
                            end
                        end
                        else if (!long_done_eff && !held_short)
                        begin
                            long_done_next = 1'b1;
                            ev             = EV_LONG;
                        end
                    end
                end
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    assign result.has_result = (func_t'(item.func) == FUNC_POLL);
    assign result.event_code = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_clock_reg <= 1'b1;
            down_reg       <= 1'b0;
            long_done_reg  <= 1'b0;
            start_reg      <= '0;
            ms_reg         <= '0;
            long_press_reg <= LongPressReset;
        end
        else
        begin
            if (advance)
            begin
                count_reg      <= count_next;
                last_clock_reg <= last_clock_next;
                down_reg       <= down_next;
                long_done_reg  <= long_done_next;
                start_reg      <= start_next;
                ms_reg         <= ms_next;
            end
            if (cfg_wr_en)
            begin
                long_press_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ sv/reb_out_stage.sv @@
// Result register for the rotary encoder button event block.
// Depends on reb_pkg for the result type.
module reb_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  reb_pkg::reb_result_t result,
    input  logic                 out_stall,
    output logic                 out_free,
    output logic                 out_valid,
    output logic [2:0]           event_res
);
    import reb_pkg::*;

    logic       valid_reg, valid_next;
    logic [2:0] event_reg;

    // The slot takes a new beat when empty or draining this cycle.
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign event_res = event_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= result.event_code;
        end
    end

endmodule

@@ sv/rotary_encoder_button_events_top.sv @@
// Top level of the rotary encoder button event block.
// Depends on reb_pkg, reb_in_stage, reb_core and reb_out_stage.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  func, clk_level, dt_level, switch_level
//   out      output     out_valid/out_stall  event_res
//   cfg      input      cfg_wr_en            cfg_wr_data (long_press_ms)
//
// Each beat is held in the input register, where the state update and event
// decode run; a poll's event is written to the result register as the beat advances.
// Throughput is one beat per cycle (single input register) unless a poll waits.
// Reset clears the count, timers and press state and loads long_press_ms 1000.
// A stalled result holds; any non-poll beat still moves past it, a poll waits.
module rotary_encoder_button_events_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic                          clk_level,
    input  logic                          dt_level,
    input  logic                          switch_level,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    event_res,
    input  logic                          cfg_wr_en,
    input  logic [reb_pkg::HoldWidth-1:0] cfg_wr_data
);
    import reb_pkg::*;

    reb_item_t   in_item;
    reb_item_t   item;
    logic        item_valid;
    reb_result_t result;
    logic        out_free;
    logic        advance;

    assign in_item.func         = func;
    assign in_item.clk_level    = clk_level;
    assign in_item.dt_level     = dt_level;
    assign in_item.switch_level = switch_level;

    // Advance the held beat unless it is a poll and the result slot is full.
    assign advance = item_valid && (!result.has_result || out_free);

    reb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .advance    (advance),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item       (item)
    );

    reb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .advance     (advance),
        .result      (result)
    );

    reb_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && result.has_result),
        .result    (result),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .event_res (event_res)
    );

endmodule

@@ dv/rotary_encoder_button_events_top_tb.sv @@
// Self-checking testbench for rotary_encoder_button_events_top.
// Depends on reb_pkg and the block's RTL; an in-bench predictor checks each poll result.
module rotary_encoder_button_events_top_tb;
    import reb_pkg::*;

    // Cycles the receiver holds off in its one long stretch of back-pressure.
    localparam int LongHoldCycles = 400;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int WatchdogLimit  = 3000;
    // Cycles to let the block settle after the last result, before a register
    // write or the final verdict; pin changes and ticks leave no result behind.
    localparam int DrainCycles    = 8;
    // Counted beats per random phase (saturation runs come on top).
    localparam int PhaseBeats     = 110;
    // Phases that carry the saturation runs and the long receiver hold.
    localparam int SatUpPhase     = 2;
    localparam int SatDownPhase   = 3;
    localparam int PressurePhase  = 4;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_RARE,
        STALL_COMB,
        STALL_HEAVY
    } stall_mode_t;

    // Block ports; every input starts at a known value.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [1:0]           func         = FUNC_PIN;
    logic                 clk_level    = 1'b1;
    logic                 dt_level     = 1'b0;
    logic                 switch_level = 1'b1;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [2:0]           event_res;
    logic                 cfg_wr_en    = 1'b0;
    logic [HoldWidth-1:0] cfg_wr_data  = LongPressReset;

    // Predictor state, mirroring the block's registers after reset.
    logic [HoldWidth-1:0]         hold_ms   = LongPressReset;
    logic signed [CountWidth-1:0] turns     = '0;
    logic                         clk_seen  = 1'b1;
    logic                         pressed_q = 1'b0;
    logic                         long_sent = 1'b0;
    logic [TimeWidth-1:0]         press_at  = '0;
    logic [TimeWidth-1:0]         now_ms    = '0;

    // Beats waiting to be sent (head is the one on the wires while in_valid),
    // and poll events predicted but not yet seen on the output.
    reb_item_t outgoing_beats[$];
    event_t    awaited_events[$];

    // Bookkeeping shared between processes; each has a single writer.
    logic        in_taken     = 1'b0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          holds_asked  = 0;
    int          holds_served = 0;
    int          beats_made   = 0;
    logic [HoldWidth-1:0] gen_hold = LongPressReset;
    event_t      want_event;
    reb_item_t   seen_beat;

    // Driver-private burst and gap counters.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver-private stall pattern state.
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          hold_left  = 0;
    int          comb_step  = 0;

    rotary_encoder_button_events_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .clk_level    (clk_level),
        .dt_level     (dt_level),
        .switch_level (switch_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Press timer, run by a poll only when no rotation is pending.
    function automatic event_t press_timer(input logic pressed);
        logic [TimeWidth-1:0] held;
        if (pressed && !pressed_q)
        begin
            pressed_q = 1'b1;
            long_sent = 1'b0;
            press_at  = now_ms;
        end
        if (!pressed_q)
            return EV_NONE;
        held = now_ms - press_at;
        if (!pressed)
        begin
            pressed_q = 1'b0;
            if (!long_sent && held < TimeWidth'(hold_ms))
                return EV_CLICK;
        end
        else if (!long_sent && held >= TimeWidth'(hold_ms))
        begin
            long_sent = 1'b1;
            return EV_LONG;
        end
        return EV_NONE;
    endfunction

    // Advance the predicted state by one accepted beat; a poll queues its event.
    function automatic void predict_beat(input reb_item_t beat);
        event_t ev;
        case (beat.func)
            FUNC_PIN:
            begin
                // Only a clock change matters, and only a falling one counts.
                if (beat.clk_level != clk_seen)
                begin
                    clk_seen = beat.clk_level;
                    if (!beat.clk_level)
                    begin
                        if (beat.dt_level != beat.clk_level)
                        begin
                            if (turns < CountMax)
                                turns = turns + 8'sd1;
                        end
                        else if (turns > CountMin)
                        begin
                            turns = turns - 8'sd1;
                        end
                    end
                end
            end
            FUNC_TICK:
                now_ms = now_ms + 1;
            FUNC_POLL:
            begin
                // Pending rotation wins and skips the button logic.
                if (turns > 0)
                    ev = EV_CW;
                else if (turns < 0)
                    ev = EV_CCW;
                else
                    ev = press_timer(!beat.switch_level);
                turns = '0;
                awaited_events.push_back(ev);
            end
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample at the rising edge, predict inputs, check outputs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (cfg_wr_en)
                hold_ms = cfg_wr_data;
            // Check the output beat first; it always belongs to an earlier poll.
            if (out_valid && !out_stall)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("event_res %0d arrived with no poll outstanding", event_res);
                    mismatches++;
                end
                else
                begin
                    want_event = awaited_events.pop_front();
                    if (event_res !== want_event)
                    begin
                        $error("event_res mismatch: expected %0d (%s), actual %0d",
                               want_event, want_event.name(), event_res);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                seen_beat = {func, clk_level, dt_level, switch_level};
                predict_beat(seen_beat);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either channel for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold a stalled beat; after
    // an accepted beat drop it and either offer the next or open a gap.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_valid)
                void'(outgoing_beats.pop_front());
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (outgoing_beats.size() != 0)
            begin
                in_valid     <= 1'b1;
                func         <= outgoing_beats[0].func;
                clk_level    <= outgoing_beats[0].clk_level;
                dt_level     <= outgoing_beats[0].dt_level;
                switch_level <= outgoing_beats[0].switch_level;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // New burst; mostly short gaps, now and then a long one.
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(5, 24);
                    else
                        gap_left = $urandom_range(0, 2);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that switches between modes; on request
    // hold off for a long stretch counted here.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            hold_left    = LongHoldCycles - 1;
            out_stall   <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 4));
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            comb_step++;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                STALL_RARE:  out_stall <= ($urandom_range(0, 7) == 0);
                STALL_COMB:  out_stall <= (comb_step % 4 != 0);
                default:     out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders (no time passes here).
    // ------------------------------------------------------------------
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void push_beat(input func_t kind, input logic c, input logic d,
                                      input logic s);
        reb_item_t b;
        b.func         = kind;
        b.clk_level    = c;
        b.dt_level     = d;
        b.switch_level = s;
        outgoing_beats.push_back(b);
        if (kind != FUNC_IDLE)
            beats_made++;
    endfunction

    // Poll with the switch pressed or released; the encoder bits are don't-care.
    function automatic void push_poll(input logic held);
        push_beat(FUNC_POLL, rand_bit(), rand_bit(), !held);
    endfunction

    function automatic void push_ticks(input int n);
        repeat (n) push_beat(FUNC_TICK, rand_bit(), rand_bit(), rand_bit());
    endfunction

    // One detent: clock falls with data set by direction, then rises.
    function automatic void push_detent(input logic cw);
        push_beat(FUNC_PIN, 1'b0, cw, rand_bit());
        push_beat(FUNC_PIN, 1'b1, rand_bit(), rand_bit());
    endfunction

    // Drive the count past one limit, then back by exactly the limit: a poll
    // afterwards sees zero only if the count saturated on the way out.
    function automatic void push_saturation(input logic cw);
        push_poll(1'b0);
        repeat (130) push_detent(cw);
        repeat (127) push_detent(!cw);
        push_poll(rand_bit());
    endfunction

    // One random sequence: mostly well-formed turns and presses, some noise.
    function automatic void push_scenario();
        int pick;
        int n;
        int span;
        pick = $urandom_range(0, 99);
        span = (gen_hold <= 12) ? int'(gen_hold) + 2 : 4;
        if (pick < 35)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                // Occasional contact bounce between detents.
                if ($urandom_range(0, 4) == 0)
                    push_beat(FUNC_PIN, rand_bit(), rand_bit(), rand_bit());
                push_detent(rand_bit());
            end
            push_poll(rand_bit());
        end
        else if (pick < 70)
        begin
            // Press, hold across some ticks with polls, release.
            push_poll(1'b1);
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                push_ticks($urandom_range(0, span));
                if ($urandom_range(0, 5) == 0)
                    push_detent(rand_bit());
                push_poll(1'b1);
            end
            push_poll(1'b0);
        end
        else if (pick < 85)
        begin
            push_ticks($urandom_range(0, 3));
            push_poll(rand_bit());
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                push_beat(func_t'($urandom_range(0, 3)), rand_bit(), rand_bit(), rand_bit());
        end
    endfunction

    // Wait until every beat is sent and every result is in, then let the
    // block settle.
    task automatic settle();
        @(negedge clk);
        while (outgoing_beats.size() != 0 || in_valid || awaited_events.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Write long_press_ms while the block is idle.
    task automatic write_hold(input logic [HoldWidth-1:0] ms);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ms;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        gen_hold = ms;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [HoldWidth-1:0] phase_hold [6];
        int                   phase_start;

        phase_hold = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd7, 16'd2};
        phase_hold[5] = HoldWidth'($urandom_range(1, 12));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset hold time.
        push_poll(1'b0);                          // nothing pending: no event
        push_beat(FUNC_PIN, 1'b1, 1'b0, 1'b0);    // clock already high: no change
        push_beat(FUNC_PIN, 1'b0, 1'b1, 1'b0);    // falling, data differs: up
        push_beat(FUNC_PIN, 1'b0, 1'b0, 1'b1);    // clock unchanged
        push_beat(FUNC_PIN, 1'b1, 1'b1, 1'b1);    // rising edge: clock stored only
        push_poll(1'b0);                          // clockwise
        push_detent(1'b0);
        push_poll(1'b1);                          // counterclockwise beats the switch
        push_poll(1'b1);                          // press starts
        push_ticks(2);
        push_beat(FUNC_IDLE, 1'b1, 1'b1, 1'b1);   // unused kind: ignored
        push_poll(1'b0);                          // click

        // Zero hold time: long press on the first pressed poll, never a click.
        write_hold(16'd0);
        push_poll(1'b1);
        push_poll(1'b1);
        push_poll(1'b0);
        push_poll(1'b0);

        // One millisecond: long press after one tick, click without one.
        write_hold(16'd1);
        push_poll(1'b1);
        push_ticks(1);
        push_poll(1'b1);
        push_poll(1'b0);
        push_poll(1'b1);
        push_poll(1'b0);

        // Largest hold time: release always clicks.
        write_hold(16'hFFFF);
        push_poll(1'b1);
        push_ticks(3);
        push_poll(1'b0);

        // Random phases, each at its own hold time; the drain before each
        // write doubles as a sender pause until every result is back.
        foreach (phase_hold[p])
        begin
            write_hold(phase_hold[p]);
            if (p == PressurePhase)
                holds_asked++;
            if (p == SatUpPhase)
                push_saturation(1'b1);
            if (p == SatDownPhase)
                push_saturation(1'b0);
            phase_start = beats_made;
            while (beats_made - phase_start < PhaseBeats)
                push_scenario();
        end

        settle();
        if (mismatches == 0 && awaited_events.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
sv/reb_pkg.sv
sv/reb_in_stage.sv
sv/reb_core.sv
sv/reb_out_stage.sv
sv/rotary_encoder_button_events_top.sv
dv/rotary_encoder_button_events_top_tb.sv
